// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg - shared types for the stable sorted priority queue
// Entry layout, operation and status codes, and the control bundle that the
// top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int PRIO_W = 8;
  localparam int PAY_W  = 8;
  localparam int DUR_W  = 16;
  localparam int OCC_W  = 5;

  // operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [PAY_W-1:0]  payload;
    logic [DUR_W-1:0]  duration;
  } entry_t;

  // broadcast to every cell in the cycle of a transfer
  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell - one slot of the sorted chain
// Holds one entry; on insert it holds, loads the new entry or takes its left
// neighbor's; on remove it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire                      clk,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire                      occupied,
  input  wire                      left_gt,
  input  wire spq_pkg::entry_t     left_entry,
  input  wire spq_pkg::entry_t     right_entry,
  output logic                     gt,
  output spq_pkg::entry_t          entry
);

  spq_pkg::entry_t entry_next;

  // an empty slot counts as greater, so a new entry that no stored entry exceeds lands behind all stored ones
  assign gt = !occupied || (entry.prio > ctrl.new_entry.prio);

  always_comb begin
    entry_next = entry;
    if (ctrl.remove) begin
      entry_next = right_entry;
    end else if (ctrl.insert && gt) begin
      entry_next = left_gt ? left_entry : ctrl.new_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// ===== sv/stable_sorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_unit - bounded sorted queue with stable ties
// Chain of QUEUE_DEPTH cells kept in ascending priority order; insert and
// remove-head commands, one status result per command.
// ----------------------------------------------------------------------------
// Each input transfer is one command: insert (func = insert) places the entry
// behind every stored entry of equal or lower priority value, so lower values
// leave first and equal values leave in arrival order; remove pops the head.
// Every command yields exactly one result transfer carrying the status (ok,
// full with the insert dropped, or empty with nothing removed), the removed
// entry when there is one, and the count after the command. One command is
// taken per clock unless a waiting result is not taken: every cell compares
// its priority with the new one in parallel and the chain shifts by one place.
// The result register shows each result in the cycle after its command is
// taken; a command is taken while a result waits if that result is taken in
// the same cycle. No clearing pass follows reset: the fill count alone marks
// the filled cells. Occupancy reports the count modulo 32 for depths above 31.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_sorted_priority_queue_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst,
  // command channel
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         func,
  input  wire  [7:0]  priority_req,
  input  wire  [7:0]  payload,
  input  wire  [15:0] duration,
  // result channel
  output logic        res_valid,
  input  wire         res_ready,
  output logic [1:0]  status,
  output logic        out_valid,
  output logic [7:0]  out_priority,
  output logic [7:0]  out_payload,
  output logic [15:0] out_duration,
  output logic [4:0]  occupancy,
  output logic        is_empty
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int EXT_W = (CNT_W > spq_pkg::OCC_W) ? CNT_W : spq_pkg::OCC_W;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic             xfer_in;
  logic             is_full;
  logic             is_none;
  logic             do_insert;
  logic             do_remove;

  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_gt;
  logic [QUEUE_DEPTH-1:0] cell_occ;

  spq_pkg::status_t status_next;
  logic [EXT_W-1:0] count_ext;

  // result register frees up when its transfer completes
  assign in_ready = !res_valid || res_ready;
  assign xfer_in  = in_valid && in_ready;

  assign is_full   = (count >= CNT_W'(QUEUE_DEPTH));
  assign is_none   = (count == '0);
  assign do_insert = xfer_in && (func == spq_pkg::FUNC_INSERT) && !is_full;
  assign do_remove = xfer_in && (func == spq_pkg::FUNC_REMOVE) && !is_none;

  always_comb begin
    ctrl.insert             = do_insert;
    ctrl.remove             = do_remove;
    ctrl.new_entry.prio     = priority_req;
    ctrl.new_entry.payload  = payload;
    ctrl.new_entry.duration = duration;
  end

  // build the chain: each cell sees its left neighbor for insert shifts and
  // its right neighbor for remove shifts; the ends see nothing useful
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_e;
    spq_pkg::entry_t right_e;
    logic            left_g;

    assign cell_occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign left_g = 1'b0;
      assign left_e = '0;
    end else begin : g_mid
      assign left_g = cell_gt[i-1];
      assign left_e = cell_entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (cell_occ[i]),
      .left_gt     (left_g),
      .left_entry  (left_e),
      .right_entry (right_e),
      .gt          (cell_gt[i]),
      .entry       (cell_entry[i])
    );
  end

  // advance the fill count
  always_comb begin
    count_next = count;
    if (do_insert) begin
      count_next = count + CNT_W'(1);
    end else if (do_remove) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    status_next = spq_pkg::STATUS_OK;
    if (func == spq_pkg::FUNC_INSERT) begin
      if (is_full) begin
        status_next = spq_pkg::STATUS_FULL;
      end
    end else if (is_none) begin
      status_next = spq_pkg::STATUS_EMPTY;
    end
  end

  assign count_ext = EXT_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (xfer_in) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // capture the result of the accepted command; hold it otherwise
  always_ff @(posedge clk) begin
    if (xfer_in) begin
      status       <= status_next;
      out_valid    <= do_remove;
      out_priority <= do_remove ? cell_entry[0].prio : '0;
      out_payload  <= do_remove ? cell_entry[0].payload : '0;
      out_duration <= do_remove ? cell_entry[0].duration : '0;
      occupancy    <= count_ext[spq_pkg::OCC_W-1:0];
      is_empty     <= (count_next == '0);
    end
  end

endmodule

`default_nettype wire
